// ===== hw/rtl/tgsbd_pkg.sv =====
// ----------------------------------------------------------------------------
// tgsbd_pkg
// Shared types and codes for the grid step and hop distance block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tgsbd_pkg;

   // Function codes carried in req_tuser
   localparam logic [1:0] FUNC_WRITE = 2'd0;
   localparam logic [1:0] FUNC_STEP  = 2'd1;
   localparam logic [1:0] FUNC_DIST  = 2'd2;

   // Axis codes
   localparam logic [2:0] AXIS_POS_A = 3'd0;
   localparam logic [2:0] AXIS_NEG_A = 3'd1;
   localparam logic [2:0] AXIS_POS_B = 3'd2;
   localparam logic [2:0] AXIS_NEG_B = 3'd3;
   localparam logic [2:0] AXIS_POS_C = 3'd4;
   localparam logic [2:0] AXIS_NEG_C = 3'd5;

   localparam logic [15:0] FAR_AWAY = 16'hFFFF;

   // Kind of move the shared move unit evaluates
   typedef enum logic [1:0] {
      MOVE_POS,
      MOVE_NEG,
      MOVE_VERT,
      MOVE_NONE
   } move_kind_type;

   // One adjacency entry, 13 bits
   typedef struct packed {
      logic [7:0] vert_point;
      logic       has_vert_nbr;
      logic       odd_cell;
      logic       reversed_strip;
      logic       has_neg_nbr;
      logic       has_pos_nbr;
   } entry_type;

endpackage

// ===== hw/rtl/tri_grid_step_and_bfs_distance.sv =====
// ----------------------------------------------------------------------------
// tri_grid_step_and_bfs_distance
// Adjacency table, single-axis step and breadth-first hop distance.
// ----------------------------------------------------------------------------
// One request is handled at a time. A step query goes through a table read,
// the move and the result. A distance query visits every point reached from
// the start: each dequeued point costs a queue read, a table read and a relax
// step for each of its neg, pos and vert neighbors through the one shared
// move unit, with one table and one queue memory port. Visited flags are
// flip-flops cleared at the start of each query, so no clearing pass is
// needed. The usable grid is the first min(NODES, 256) points.
`timescale 1ns / 1ps

module tri_grid_step_and_bfs_distance #(
   parameter int NODES = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [7:0] point, [8] point_present, [16:9] target, [19:17] axis,
   // [20] has_pos_nbr, [21] has_neg_nbr, [22] reversed_strip, [23] odd_cell,
   // [24] has_vert_nbr, [32:25] vert_point, [39:33] zero
   input  logic [39:0] req_tdata,
   // [1:0] func
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] result_point, [8] result_present, [24:9] hops, [31:25] zero
   output logic [31:0] rsp_tdata
);
   import tgsbd_pkg::*;

   localparam int GRID = (NODES < 256) ? NODES : 256;
   localparam int PW   = (GRID > 1) ? $clog2(GRID) : 1;
   localparam int QW   = PW + 16;

   typedef enum logic [2:0] {
      S_IDLE, S_STEP, S_POP, S_FETCH, S_REL, S_RESP
   } state_type;

   // Request fields
   logic [7:0] f_point, f_target, f_vert;
   logic       f_present;
   logic [2:0] f_axis;
   entry_type  f_entry;
   assign f_point   = req_tdata[7:0];
   assign f_present = req_tdata[8];
   assign f_target  = req_tdata[16:9];
   assign f_axis    = req_tdata[19:17];
   assign f_vert    = req_tdata[32:25];
   assign f_entry   = '{vert_point: f_vert, has_vert_nbr: req_tdata[24],
                        odd_cell: req_tdata[23], reversed_strip: req_tdata[22],
                        has_neg_nbr: req_tdata[21], has_pos_nbr: req_tdata[20]};

   logic pt_in, tg_in;
   assign pt_in = {1'b0, f_point} < 9'(GRID);
   assign tg_in = {1'b0, f_target} < 9'(GRID);

   // Memories
   entry_type         tbl_mem [GRID];
   logic [QW-1:0]     q_mem   [GRID];
   entry_type         tbl_rd_ff;
   logic [QW-1:0]     q_rd_ff;

   // State
   state_type         state_ff;
   logic [PW-1:0]     cur_ff, tgt_ff, rp_ff, wp_ff;
   logic [15:0]       dist_ff, hops_ff;
   logic [2:0]        axis_ff;
   logic [1:0]        rel_ff;
   logic [GRID-1:0]   vis_ff;
   logic              rsp_valid_ff;
   logic [7:0]        res_point_ff;
   logic              res_present_ff;
   logic [15:0]       res_hops_ff;

   logic              accept;
   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, res_hops_ff, res_present_ff, res_point_ff};

   // Move kind: step decodes the axis, search walks neg, pos, vert
   move_kind_type kind;
   always_comb begin
      kind = MOVE_NONE;
      if (state_ff == S_STEP) begin
         unique case (axis_ff)
            AXIS_POS_A: kind = MOVE_POS;
            AXIS_NEG_A: kind = MOVE_NEG;
            AXIS_POS_B: kind = tbl_rd_ff.odd_cell ? MOVE_VERT : MOVE_NEG;
            AXIS_NEG_B: kind = tbl_rd_ff.odd_cell ? MOVE_POS  : MOVE_VERT;
            AXIS_POS_C: kind = tbl_rd_ff.odd_cell ? MOVE_NEG  : MOVE_VERT;
            AXIS_NEG_C: kind = tbl_rd_ff.odd_cell ? MOVE_VERT : MOVE_POS;
            default:    kind = MOVE_NONE;
         endcase
      end else begin
         case (rel_ff)
            2'd0:    kind = MOVE_NEG;
            2'd1:    kind = MOVE_POS;
            default: kind = MOVE_VERT;
         endcase
      end
   end

   // Shared move unit: a +1 and a -1 adder and a grid bound compare
   logic       go_up, mv_ok;
   logic [8:0] up_val, dn_val, mv_dst9;
   assign up_val = {1'b0, 8'(cur_ff)} + 9'd1;
   assign dn_val = {1'b0, 8'(cur_ff)} - 9'd1;
   always_comb begin
      go_up   = 1'b0;
      mv_ok   = 1'b0;
      mv_dst9 = {1'b0, tbl_rd_ff.vert_point};
      unique case (kind)
         MOVE_POS: begin
            go_up = !tbl_rd_ff.reversed_strip;
            mv_ok = tbl_rd_ff.has_pos_nbr;
         end
         MOVE_NEG: begin
            go_up = tbl_rd_ff.reversed_strip;
            mv_ok = tbl_rd_ff.has_neg_nbr;
         end
         MOVE_VERT: mv_ok = tbl_rd_ff.has_vert_nbr;
         default:   mv_ok = 1'b0;
      endcase
      if (kind == MOVE_POS || kind == MOVE_NEG) begin
         mv_dst9 = go_up ? up_val : dn_val;
         if (!go_up && cur_ff == '0) mv_ok = 1'b0;
      end
      if (mv_dst9 >= 9'(GRID)) mv_ok = 1'b0;
   end

   logic [PW-1:0] mv_dst;
   assign mv_dst = mv_dst9[PW-1:0];

   logic [PW-1:0] rp_inc, wp_inc;
   assign rp_inc = (rp_ff == PW'(GRID - 1)) ? '0 : rp_ff + 1'b1;
   assign wp_inc = (wp_ff == PW'(GRID - 1)) ? '0 : wp_ff + 1'b1;

   logic relax_en;
   assign relax_en = (state_ff == S_REL) && mv_ok && !vis_ff[mv_dst];

   // Table memory: write on a write request, read on step or dequeue
   always_ff @(posedge clock) begin
      if (accept && req_tuser == FUNC_WRITE && pt_in)
         tbl_mem[f_point[PW-1:0]] <= f_entry;
      if (state_ff == S_IDLE)
         tbl_rd_ff <= tbl_mem[f_point[PW-1:0]];
      else if (state_ff == S_FETCH)
         tbl_rd_ff <= tbl_mem[q_rd_ff[QW-1:16]];
   end

   // Queue memory: holds point and its distance
   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE) begin
         if (accept && req_tuser == FUNC_DIST)
            q_mem[0] <= {f_point[PW-1:0], 16'd0};
      end else if (relax_en) begin
         q_mem[wp_ff] <= {mv_dst, dist_ff};
      end
      if (state_ff == S_POP)
         q_rd_ff <= q_mem[rp_ff];
   end

   // Sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         rp_ff        <= '0;
         wp_ff        <= '0;
         rel_ff       <= '0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  cur_ff  <= f_point[PW-1:0];
                  tgt_ff  <= f_target[PW-1:0];
                  axis_ff <= f_axis;
                  case (req_tuser)
                     FUNC_STEP: begin
                        if (f_present && pt_in) begin
                           state_ff <= S_STEP;
                        end else begin
                           res_point_ff   <= '0;
                           res_present_ff <= 1'b0;
                           res_hops_ff    <= '0;
                           rsp_valid_ff   <= 1'b1;
                           state_ff       <= S_RESP;
                        end
                     end
                     FUNC_DIST: begin
                        if (f_present && pt_in && tg_in) begin
                           // Mark only the start point as reached
                           vis_ff   <= GRID'(1) << f_point[PW-1:0];
                           rp_ff    <= '0;
                           wp_ff    <= (GRID > 1) ? PW'(1) : '0;
                           hops_ff  <= (f_point == f_target) ? 16'd0 : FAR_AWAY;
                           state_ff <= S_POP;
                        end else begin
                           res_point_ff   <= '0;
                           res_present_ff <= 1'b0;
                           res_hops_ff    <= FAR_AWAY;
                           rsp_valid_ff   <= 1'b1;
                           state_ff       <= S_RESP;
                        end
                     end
                     default: state_ff <= S_IDLE;
                  endcase
               end
            end
            S_STEP: begin
               res_point_ff   <= mv_ok ? mv_dst9[7:0] : 8'd0;
               res_present_ff <= mv_ok;
               res_hops_ff    <= '0;
               rsp_valid_ff   <= 1'b1;
               state_ff       <= S_RESP;
            end
            S_POP: begin
               if (rp_ff == wp_ff) begin
                  res_point_ff   <= '0;
                  res_present_ff <= 1'b0;
                  res_hops_ff    <= hops_ff;
                  rsp_valid_ff   <= 1'b1;
                  state_ff       <= S_RESP;
               end else begin
                  state_ff <= S_FETCH;
               end
            end
            S_FETCH: begin
               cur_ff   <= q_rd_ff[QW-1:16];
               dist_ff  <= q_rd_ff[15:0] + 16'd1;
               rp_ff    <= rp_inc;
               rel_ff   <= '0;
               state_ff <= S_REL;
            end
            S_REL: begin
               // Enqueue a neighbor that has not been reached yet
               if (relax_en) begin
                  vis_ff[mv_dst] <= 1'b1;
                  wp_ff          <= wp_inc;
                  if (mv_dst == tgt_ff) hops_ff <= dist_ff;
               end
               if (rel_ff == 2'd2) state_ff <= S_POP;
               rel_ff <= rel_ff + 2'd1;
            end
            S_RESP: begin
               if (rsp_tready) begin
                  rsp_valid_ff <= 1'b0;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule
